// File: src/byte_stream_lexer_defines.svh
// ----------------------------------------------------------------------------
// byte_stream_lexer_defines.svh
// Assertion macros shared by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_LEXER_DEFINES_SVH
`define BYTE_STREAM_LEXER_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define BSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define BSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Types, token kind codes and character classes for the byte stream lexer.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int ByteW  = 8;
  localparam int KindW  = 5;
  localparam int ValueW = 32;
  localparam int NumOps = 14;

  localparam logic [KindW-1:0] K_NAME    = 5'd14;
  localparam logic [KindW-1:0] K_CONST   = 5'd15;
  localparam logic [KindW-1:0] K_UNKNOWN = 5'd16;
  localparam logic [KindW-1:0] K_END     = 5'd17;

  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_NEWLINE = 8'h0A;

  // operator characters, index = token kind
  localparam logic [ByteW-1:0] OP_CHARS [NumOps] = '{
    8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h7C,
    8'h26, 8'h25, 8'h7E, 8'h2E, 8'h28, 8'h29, 8'h22
  };

  typedef enum logic [1:0] {
    M_IDLE,
    M_NAME,
    M_NUMBER,
    M_ERROR
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NAME,
    S_NUM,
    S_TAIL
  } st_e;

  typedef struct packed {
    logic             hit;
    logic [KindW-1:0] kind;
  } op_hit_t;

  function automatic logic is_letter(input logic [ByteW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic op_hit_t op_lookup(input logic [ByteW-1:0] c);
    op_hit_t r;
    r = '0;
    for (int i = 0; i < NumOps; i++) begin
      if (OP_CHARS[i] == c) begin
        r.hit  = 1'b1;
        r.kind = KindW'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: src/bsl_if.sv
// ----------------------------------------------------------------------------
// bsl_if
// Valid/ready channels for source bytes and for token results.
// ----------------------------------------------------------------------------
interface bsl_byte_if import bsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface bsl_tok_if import bsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  tok_kind;
  logic [ValueW-1:0] int_value;
  logic [ByteW-1:0]  tok_char;
  logic              last_in_run;

  modport source (output valid, output tok_kind, output int_value, output tok_char,
                  output last_in_run, input ready);
  modport sink   (input valid, input tok_kind, input int_value, input tok_char,
                  input last_in_run, output ready);
endinterface

// File: src/bsl_ram.sv
// ----------------------------------------------------------------------------
// bsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsl_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/byte_stream_lexer.sv
// ----------------------------------------------------------------------------
// byte_stream_lexer
// Source byte tokenizer: operators, names, decimal constants, unknown bytes, end marker.
//
// Channels: byte_i takes one source byte or an end-of-input marker per
// transfer; tok_o delivers one token result per transfer. A name comes out
// as one result per character, the last one flagged by last_in_run.
// Steps: an item that ends no pending token is accepted, then handled in
// an update step (S_TAIL); a source byte in error mode is accepted and dropped.
// Ending a pending name first reads the held characters back from the name
// RAM, one per cycle while the receiver is free (S_NAME); ending a constant
// first emits its value (S_NUM). An item's own result (operator, unknown
// byte, end) leaves the output register in the cycle after its update step.
// Reset: mode idle, counters and accumulator cleared; the name RAM is not
// cleared, only entries written in the current name are ever read.
// Receiver stall: the output register holds its result and any step that emits
// a result waits; byte_i stays not ready until the current item is done.
// ----------------------------------------------------------------------------
`include "byte_stream_lexer_defines.svh"

module byte_stream_lexer import bsl_pkg::*; #(
  parameter int NAME_MAX   = 16,
  parameter int DIGITS_MAX = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bsl_byte_if.sink         byte_i,
  bsl_tok_if.source        tok_o
);

  localparam int CntW  = $clog2(NAME_MAX + 1);
  localparam int AddrW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int DigW  = $clog2(DIGITS_MAX + 1);

  st_e                 state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [CntW-1:0]     name_cnt_q, name_cnt_d;
  logic [DigW-1:0]     dig_cnt_q, dig_cnt_d;
  logic [ValueW-1:0]   accum_q, accum_d;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic                eoi_q, eoi_d;
  logic                flush_q, flush_d;
  logic [AddrW-1:0]    idx_q, idx_d;

  logic                ovalid_q, ovalid_d;
  logic [KindW-1:0]    okind_q, okind_d;
  logic [ValueW-1:0]   oval_q, oval_d;
  logic [ByteW-1:0]    ochar_q, ochar_d;
  logic                olast_q, olast_d;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [ByteW-1:0]    ram_wdata, ram_rdata;

  logic                in_acc, out_free, need, name_last;
  logic [CntW-1:0]     base_cnt;
  logic [DigW-1:0]     base_dig;
  logic [ValueW-1:0]   base_acc;
  op_hit_t             op;

  bsl_ram #(
    .Width (ByteW),
    .Depth (NAME_MAX)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign byte_i.ready      = (state_q == S_IDLE);
  assign in_acc            = byte_i.valid && byte_i.ready;
  assign out_free          = !ovalid_q || tok_o.ready;

  assign tok_o.valid       = ovalid_q;
  assign tok_o.tok_kind    = okind_q;
  assign tok_o.int_value   = oval_q;
  assign tok_o.tok_char    = ochar_q;
  assign tok_o.last_in_run = olast_q;

  assign base_cnt  = flush_q ? '0 : name_cnt_q;
  assign base_dig  = flush_q ? '0 : dig_cnt_q;
  assign base_acc  = flush_q ? '0 : accum_q;
  assign name_last = (CntW'(idx_q) + CntW'(1)) == name_cnt_q;
  assign op        = op_lookup(byte_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    name_cnt_d = name_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    accum_d    = accum_q;
    byte_d     = byte_q;
    eoi_d      = eoi_q;
    flush_d    = flush_q;
    idx_d      = idx_q;
    ovalid_d   = ovalid_q && !tok_o.ready;
    okind_d    = okind_q;
    oval_d     = oval_q;
    ochar_d    = ochar_q;
    olast_d    = olast_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = byte_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    need       = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_acc && (byte_i.end_of_input || mode_q != M_ERROR)) begin
          byte_d = byte_i.in_byte;
          eoi_d  = byte_i.end_of_input;
          if (byte_i.end_of_input) begin
            need = 1'b1;
          end else if (is_letter(byte_i.in_byte)) begin
            need = (mode_q != M_NAME) || (name_cnt_q >= CntW'(NAME_MAX));
          end else if (is_digit(byte_i.in_byte)) begin
            need = (mode_q != M_NUMBER) || (dig_cnt_q >= DigW'(DIGITS_MAX));
          end
          flush_d = need;
          if (need && mode_q == M_NAME) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_NAME;
          end else if (need && mode_q == M_NUMBER) begin
            state_d = S_NUM;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_NAME: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = K_NAME;
          oval_d   = '0;
          ochar_d  = ram_rdata;
          olast_d  = name_last;
          if (name_last) begin
            state_d = S_TAIL;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + AddrW'(1);
            idx_d     = idx_q + AddrW'(1);
          end
        end
      end
      S_NUM: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = K_CONST;
          oval_d   = accum_q;
          ochar_d  = '0;
          olast_d  = 1'b1;
          state_d  = S_TAIL;
        end
      end
      S_TAIL: begin
        if (eoi_q) begin
          if (out_free) begin
            ovalid_d   = 1'b1;
            okind_d    = K_END;
            oval_d     = '0;
            ochar_d    = '0;
            olast_d    = 1'b1;
            mode_d     = M_IDLE;
            name_cnt_d = '0;
            dig_cnt_d  = '0;
            accum_d    = '0;
            state_d    = S_IDLE;
          end
        end else if (is_letter(byte_q)) begin
          ram_we     = 1'b1;
          ram_waddr  = AddrW'(base_cnt);
          name_cnt_d = base_cnt + CntW'(1);
          dig_cnt_d  = '0;
          accum_d    = '0;
          mode_d     = M_NAME;
          state_d    = S_IDLE;
        end else if (is_digit(byte_q)) begin
          accum_d    = (base_acc << 3) + (base_acc << 1) + ValueW'(byte_q[3:0]);
          dig_cnt_d  = base_dig + DigW'(1);
          name_cnt_d = '0;
          mode_d     = M_NUMBER;
          state_d    = S_IDLE;
        end else if (byte_q == CH_SPACE || byte_q == CH_NEWLINE) begin
          mode_d     = M_IDLE;
          name_cnt_d = '0;
          dig_cnt_d  = '0;
          accum_d    = '0;
          state_d    = S_IDLE;
        end else if (out_free) begin
          ovalid_d   = 1'b1;
          okind_d    = op.hit ? op.kind : K_UNKNOWN;
          oval_d     = '0;
          ochar_d    = byte_q;
          olast_d    = 1'b1;
          mode_d     = op.hit ? M_IDLE : M_ERROR;
          name_cnt_d = '0;
          dig_cnt_d  = '0;
          accum_d    = '0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_IDLE;
      name_cnt_q <= '0;
      dig_cnt_q  <= '0;
      accum_q    <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      name_cnt_q <= name_cnt_d;
      dig_cnt_q  <= dig_cnt_d;
      accum_q    <= accum_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    eoi_q   <= eoi_d;
    flush_q <= flush_d;
    idx_q   <= idx_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  `BSL_ASSERT(a_name_cnt_cap, name_cnt_q <= CntW'(NAME_MAX), "name count above cap")
  `BSL_ASSERT(a_dig_cnt_cap, dig_cnt_q <= DigW'(DIGITS_MAX), "digit count above cap")
  `BSL_ASSERT(a_name_nonempty, (mode_q != M_NAME) || (name_cnt_q != '0), "empty name held")
  `BSL_ASSERT_NEXT(a_err_skip,
                   in_acc && mode_q == M_ERROR && !byte_i.end_of_input,
                   state_q == S_IDLE && mode_q == M_ERROR,
                   "byte not dropped in error mode")

endmodule
